// ===== hw/rtl/awhd_pkg.sv =====
// Shared constants, types and state encodings of the area-weighted half downsampler.
package awhd_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MAX_CHANNELS  = 4;
  localparam int SAMPLE_BITS   = 16;

  localparam int DIM_BITS      = 13;
  localparam int POS_BITS      = 12;
  localparam int CH_BITS       = 2;
  localparam int CCNT_BITS     = 3;
  localparam int HSUM_BITS     = 28;
  localparam int LSUM_BITS     = 40;
  localparam int LINE_DEPTH    = (MAX_WIDTH / 2) * MAX_CHANNELS;
  localparam int LINE_AW       = 13;
  localparam int DIVISOR_BITS  = 25;
  localparam int DSH_BITS      = DIVISOR_BITS + SAMPLE_BITS - 1;
  localparam int STEP_BITS     = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [DIM_BITS-1:0]  RESET_WIDTH    = 13'd512;
  localparam logic [DIM_BITS-1:0]  RESET_HEIGHT   = 13'd512;
  localparam logic [CCNT_BITS-1:0] RESET_CHANNELS = 3'd1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } awhd_cfg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_HACC = 2'd1,
    F_LMUL = 2'd2,
    F_LWR  = 2'd3
  } awhd_front_state_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_DIV  = 2'd1,
    B_OUT  = 2'd2
  } awhd_back_state_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]     width;
    logic [DIM_BITS-1:0]     height;
    logic [CCNT_BITS-1:0]    chans;
    logic [DIVISOR_BITS-1:0] area;
  } awhd_geom_t;

  typedef struct packed {
    logic [LSUM_BITS-1:0] sum;
    logic                 last;
  } awhd_bin_t;

endpackage

// ===== hw/rtl/awhd_in_if.sv =====
// Input sample channel interface.
interface awhd_in_if;
  import awhd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

// ===== hw/rtl/awhd_out_if.sv =====
// Result sample channel interface.
interface awhd_out_if;
  import awhd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic                   last_of_image;
  modport source (output valid, output out_sample, output last_of_image, input ready);
  modport sink (input valid, input out_sample, input last_of_image, output ready);
endinterface

// ===== hw/rtl/area_weighted_half_downsampler.sv =====
// Top level of the area-weighted half downsampler.
//
//   channel  direction  payload                       handshake
//   in_ch    in         sample_value[15:0]            valid/ready
//   out_ch   out        out_sample[15:0], last_of_image valid/ready
//   cfg      in         cfg_index[1:0], cfg_data[12:0] cfg_we
//
// An item that closes no horizontal bin passes through the accept and
// accumulate states; one that closes a bin also passes through the line-store
// read, multiply and write states and may wait for space in the queue.
// Each result is loaded from the queue, divided in the bit-serial divider and
// held in the output state until taken.
// Reset is synchronous; a width, height or channel write restarts the image.
// The front keeps taking items while results wait, unless the queue is full.
module area_weighted_half_downsampler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  awhd_in_if.sink                              in_ch,
  awhd_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [awhd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [awhd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import awhd_pkg::*;

  logic [DIM_BITS-1:0]     width_r, height_r;
  logic [CCNT_BITS-1:0]    chans_r;
  logic [DIVISOR_BITS-1:0] area_r;
  logic                    restart;
  awhd_geom_t              geom;
  logic                    push_valid, push_ready, pop_valid, pop_ready;
  awhd_bin_t               push_data, pop_data;

  assign restart = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                              cfg_index == CFG_CHANNELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      chans_r <= RESET_CHANNELS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:    width_r <= cfg_data;
        CFG_HEIGHT:   height_r <= cfg_data;
        CFG_CHANNELS: chans_r <= cfg_data[CCNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.width = width_r < 13'd2 ? 13'd2 :
                 (width_r > DIM_BITS'(MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH) : width_r);
    geom.height = height_r < 13'd2 ? 13'd2 :
                  (height_r > DIM_BITS'(MAX_HEIGHT) ? DIM_BITS'(MAX_HEIGHT) : height_r);
    geom.chans = chans_r < 3'd1 ? 3'd1 :
                 (chans_r > CCNT_BITS'(MAX_CHANNELS) ? CCNT_BITS'(MAX_CHANNELS) : chans_r);
    geom.area = area_r;
  end

  always_ff @(posedge clk) begin
    area_r <= DIVISOR_BITS'(geom.width * geom.height);
  end

  awhd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .geom       (geom),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  awhd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  awhd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );
endmodule

// ===== hw/rtl/awhd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module awhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== hw/rtl/awhd_front.sv =====
// Front end: position tracking, horizontal bins and line-store accumulation.
module awhd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 restart,
  input  awhd_pkg::awhd_geom_t geom,
  awhd_in_if.sink              in_ch,
  output logic                 push_valid,
  input  logic                 push_ready,
  output awhd_pkg::awhd_bin_t  push_data
);
  import awhd_pkg::*;

  awhd_front_state_t state_r, state_nxt;

  logic [CH_BITS-1:0]   ch_r;
  logic [POS_BITS-1:0]  w_r, h_r, col_rem_r, row_rem_r;
  logic [LINE_AW-1:0]   base_r;

  logic [SAMPLE_BITS-1:0] x_r;
  logic [CH_BITS-1:0]     ich_r;
  logic [DIM_BITS-1:0]    cw1_r, cw2_r, rw1_r, rw2_r;
  logic                   close_col_r, close_row_r, first_row_r, row_end_r, last_r;
  logic [LINE_AW-1:0]     idx_r;

  logic [HSUM_BITS-1:0] hcur_r [MAX_CHANNELS];
  logic [HSUM_BITS-1:0] hnxt_r [MAX_CHANNELS];
  logic [HSUM_BITS-1:0] hval_r;
  logic [LSUM_BITS-1:0] p1_r, p2_r;

  logic [POS_BITS-1:0]  n, m;
  logic [DIM_BITS-1:0]  col_sum, row_sum;
  logic                 close_col, close_row, last_ch, row_end_pix, last_row;
  logic                 accept;
  logic [SAMPLE_BITS+DIM_BITS-1:0] prod_a, prod_b;
  logic [HSUM_BITS-1:0] hsum_a;
  logic [2*LSUM_BITS-1:0] rd_data, wr_data;
  logic [LSUM_BITS-1:0] mem_cur, mem_nxt, sum_c, sum_n;
  logic                 rd_en, wr_en;

  assign n = geom.width[DIM_BITS-1:1];
  assign m = geom.height[DIM_BITS-1:1];
  assign col_sum = {1'b0, col_rem_r} + {1'b0, n};
  assign row_sum = {1'b0, row_rem_r} + {1'b0, m};
  assign close_col = col_sum >= geom.width;
  assign close_row = row_sum >= geom.height;
  assign last_ch = {1'b0, ch_r} == geom.chans - 3'd1;
  assign row_end_pix = {1'b0, w_r} == geom.width - 13'd1;
  assign last_row = {1'b0, h_r} == geom.height - 13'd1;
  assign accept = in_ch.valid && in_ch.ready;

  assign prod_a = cw1_r * x_r;
  assign prod_b = cw2_r * x_r;
  assign hsum_a = hcur_r[ich_r] + prod_a[HSUM_BITS-1:0];

  assign mem_cur = first_row_r ? '0 : rd_data[2*LSUM_BITS-1:LSUM_BITS];
  assign mem_nxt = first_row_r ? '0 : rd_data[LSUM_BITS-1:0];
  assign sum_c = mem_cur + p1_r;
  assign sum_n = mem_nxt + p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ch.ready = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    wr_data = {sum_c, sum_n};
    push_valid = 1'b0;
    push_data.sum = sum_c;
    push_data.last = last_r;
    unique case (state_r)
      F_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = F_HACC;
        end
      end
      F_HACC: begin
        if (close_col_r) begin
          rd_en = 1'b1;
          state_nxt = F_LMUL;
        end else begin
          state_nxt = F_IDLE;
        end
      end
      F_LMUL: begin
        state_nxt = F_LWR;
      end
      F_LWR: begin
        if (close_row_r) begin
          push_valid = 1'b1;
          wr_data = {sum_n, {LSUM_BITS{1'b0}}};
          if (push_ready) begin
            wr_en = 1'b1;
            state_nxt = F_IDLE;
          end
        end else begin
          wr_en = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      ch_r <= '0;
      w_r <= '0;
      h_r <= '0;
      col_rem_r <= '0;
      row_rem_r <= '0;
      base_r <= '0;
    end else if (accept) begin
      if (last_ch) begin
        ch_r <= '0;
        if (row_end_pix) begin
          w_r <= '0;
          col_rem_r <= '0;
          base_r <= '0;
          if (last_row) begin
            h_r <= '0;
            row_rem_r <= '0;
          end else begin
            h_r <= h_r + 12'd1;
            row_rem_r <= close_row ? POS_BITS'(row_sum - geom.height) : row_sum[POS_BITS-1:0];
          end
        end else begin
          w_r <= w_r + 12'd1;
          col_rem_r <= close_col ? POS_BITS'(col_sum - geom.width) : col_sum[POS_BITS-1:0];
          base_r <= close_col ? base_r + LINE_AW'(geom.chans) : base_r;
        end
      end else begin
        ch_r <= ch_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_ch.sample_value;
      ich_r <= ch_r;
      close_col_r <= close_col;
      cw1_r <= close_col ? geom.width - {1'b0, col_rem_r} : {1'b0, n};
      cw2_r <= close_col ? col_sum - geom.width : '0;
      close_row_r <= close_row;
      rw1_r <= close_row ? geom.height - {1'b0, row_rem_r} : {1'b0, m};
      rw2_r <= close_row ? row_sum - geom.height : '0;
      idx_r <= base_r + LINE_AW'(ch_r);
      first_row_r <= h_r == '0;
      row_end_r <= row_end_pix && last_ch;
      last_r <= last_row && row_end_pix && last_ch;
    end
    if (state_r == F_LMUL) begin
      p1_r <= LSUM_BITS'(hval_r * rw1_r);
      p2_r <= LSUM_BITS'(hval_r * rw2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hcur_r[i] <= '0;
        hnxt_r[i] <= '0;
      end
    end else if (state_r == F_HACC) begin
      if (!close_col_r) begin
        hcur_r[ich_r] <= hsum_a;
      end else if (row_end_r) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          hcur_r[i] <= '0;
          hnxt_r[i] <= '0;
        end
      end else begin
        hcur_r[ich_r] <= hnxt_r[ich_r] + prod_b[HSUM_BITS-1:0];
        hnxt_r[ich_r] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_HACC) begin
      hval_r <= hsum_a;
    end
  end

  awhd_ram #(
    .WIDTH (2 * LSUM_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );
endmodule

// ===== hw/rtl/awhd_fifo.sv =====
// Two-entry queue of finished bins between front and back end.
module awhd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  awhd_pkg::awhd_bin_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output awhd_pkg::awhd_bin_t pop_data
);
  import awhd_pkg::*;

  awhd_bin_t  slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = count_r != 2'd2;
  assign pop_valid = count_r != 2'd0;
  assign pop_data = slot_r[rptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end
endmodule

// ===== hw/rtl/awhd_div.sv =====
// Back end: restoring divider by the image area and output register.
module awhd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  awhd_pkg::awhd_geom_t geom,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  awhd_pkg::awhd_bin_t pop_data,
  awhd_out_if.source          out_ch
);
  import awhd_pkg::*;

  awhd_back_state_t state_r, state_nxt;

  logic [LSUM_BITS-1:0]   rem_r;
  logic [DSH_BITS-1:0]    dsh_r;
  logic [SAMPLE_BITS-1:0] q_r;
  logic [STEP_BITS-1:0]   step_r;
  logic                   last_r;
  logic                   fits;

  assign fits = rem_r >= LSUM_BITS'(dsh_r);
  assign out_ch.out_sample = q_r;
  assign out_ch.last_of_image = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (step_r == '0) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop_valid) begin
      rem_r <= pop_data.sum;
      last_r <= pop_data.last;
      dsh_r <= {geom.area, {(SAMPLE_BITS-1){1'b0}}};
      step_r <= STEP_BITS'(SAMPLE_BITS - 1);
      q_r <= '0;
    end else if (state_r == B_DIV) begin
      if (fits) begin
        rem_r <= rem_r - LSUM_BITS'(dsh_r);
      end
      q_r <= {q_r[SAMPLE_BITS-2:0], fits};
      dsh_r <= dsh_r >> 1;
      step_r <= step_r - 4'd1;
    end
  end
endmodule

// ===== hw/rtl/awhd_checker.sv =====
// Port-level checks of the downsampler, bound to the top level.
module awhd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample,
  input logic        out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last))
    else $error("Result item changed while stalled.");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Front end took an item while still working on the previous one.");

  a_div_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("Divider showed a result without dividing.");
endmodule

bind area_weighted_half_downsampler awhd_checker u_awhd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.out_sample),
  .out_last   (out_ch.last_of_image)
);
